// ===== design/khd_pkg.sv =====
`timescale 1ns / 1ps

package khd_pkg;

    // Number of keys held in the table, and the address width it needs.
    localparam int KEY_COUNT = 512;
    localparam int ADDR_W    = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    // Fixed field widths of the stream items.
    localparam int KEY_W  = 9;
    localparam int CNT_W  = 16;
    localparam int KIND_W = 2;

    localparam logic [CNT_W-1:0] THRESHOLD_RESET = CNT_W'(22);
    localparam logic [CNT_W-1:0] COUNT_MAX       = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        PHASE_RELEASED = 2'd0,
        PHASE_PRESSED  = 2'd1,
        PHASE_BLOCKED  = 2'd2,
        PHASE_HELD     = 2'd3
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        EV_NONE     = 2'd0,
        EV_RELEASED = 2'd1,
        EV_PRESSED  = 2'd2,
        EV_HELD     = 2'd3
    } kind_t;

    // One table entry: the key's phase and its saturating down-frame count.
    typedef struct packed {
        phase_t           phase;
        logic [CNT_W-1:0] count;
    } key_state_t;

    // Write port of the key table.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        key_state_t        data;
    } table_wr_t;

endpackage

// ===== design/key_hold_detector.sv =====
`timescale 1ns / 1ps

// Per-key press and hold qualifier. Each input item carries one key's sampled
// level for one frame, and exactly one result item leaves for every input item,
// in order. A key that is up reports released with a count of zero; its first
// down frame reports pressed, the next frames report nothing while the key is
// blocked, and once its count before the frame exceeds hold_threshold every
// down frame reports held. The count saturates at 65535. The block takes one
// item per clock cycle while its results are taken. A result passes through
// the table read, the old-state register and the result register. The rate
// is set by the key table, a memory with one read and one write port, so every
// item does one read and one write. Back-to-back samples of the same key are
// handled by forwarding the freshly computed state. After reset the table is
// cleared one entry per cycle, so no item is accepted until all 512 entries
// are cleared; hold_threshold can be written during that time. Configuration
// writes are always accepted and should only be made while no item is in flight.
module key_hold_detector (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: hold_threshold.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [8:0] key_index, [9] key_down, rest zero
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [8:0] event_key, [24:9] held_frames, rest zero
    output logic [1:0]  m_axis_tuser    // [1:0] event_kind
);
    import khd_pkg::*;

    // Threshold register.
    logic [CNT_W-1:0] thr_reg;

    // Stage enables: a stage loads when it is empty or the next one moves on, so
    // bubbles are squeezed out and a waiting result blocks input only once the earlier stages are full.
    logic en1;
    logic en2;
    logic en3;

    // Stage 1: table read in flight, plus a bypass for writes that the read missed.
    logic              v1_reg;
    logic [KEY_W-1:0]  key1_reg;
    logic              down1_reg;
    logic              byp1_reg;
    key_state_t        byp1_data_reg;
    key_state_t        rd_data;
    key_state_t        st1;

    // Stage 2: resolved old state of the key.
    logic              v2_reg;
    logic [KEY_W-1:0]  key2_reg;
    logic              down2_reg;
    key_state_t        st2_reg;
    key_state_t        st2_next;

    // Stage 3: result register.
    logic              v3_reg;
    kind_t             kind3_reg;
    logic [KEY_W-1:0]  key3_reg;
    logic [CNT_W-1:0]  cnt3_reg;

    logic              clr_busy;
    logic              accept;
    logic [KEY_W-1:0]  in_key;
    logic              in_down;
    logic [ADDR_W-1:0] in_addr;
    logic [ADDR_W-1:0] addr1;
    logic              key2_ok;
    logic [CNT_W-1:0]  cnt_inc;
    logic              over_thr;
    key_state_t        new_state;
    kind_t             new_kind;
    table_wr_t         wr;

    assign in_key  = s_axis_tdata[KEY_W-1:0];
    assign in_down = s_axis_tdata[KEY_W];
    assign in_addr = ADDR_W'(in_key);
    assign addr1   = ADDR_W'(key1_reg);

    assign en3 = !v3_reg || m_axis_tready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_axis_tready = en1 && !clr_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Configuration port: always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RESET;
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    khd_key_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (en1),
        .rd_addr  (in_addr),
        .rd_data  (rd_data),
        .wr       (wr),
        .clr_busy (clr_busy)
    );

    // Stage 1 state is the table read unless a later write to the key was caught.
    assign st1 = byp1_reg ? byp1_data_reg : rd_data;

    // Stage 2 takes the write made at this very edge if it is for the same key.
    assign st2_next = (wr.en && (wr.addr == addr1)) ? wr.data : st1;

    // Next state and event for the item in stage 2.
    assign key2_ok  = int'(key2_reg) < KEY_COUNT;
    assign cnt_inc  = (st2_reg.count == COUNT_MAX) ? st2_reg.count
                                                   : st2_reg.count + CNT_W'(1);
    assign over_thr = st2_reg.count > thr_reg;

    always_comb
    begin
        new_state.count = cnt_inc;
        new_state.phase = st2_reg.phase;
        new_kind        = EV_NONE;
        if (!down2_reg)
        begin
            new_state.phase = PHASE_RELEASED;
            new_state.count = '0;
            new_kind        = EV_RELEASED;
        end
        else
        begin
            case (st2_reg.phase)
                PHASE_RELEASED:
                begin
                    new_state.phase = PHASE_PRESSED;
                    new_kind        = EV_PRESSED;
                end
                PHASE_PRESSED:
                begin
                    new_state.phase = PHASE_BLOCKED;
                    new_kind        = EV_NONE;
                end
                PHASE_BLOCKED:
                begin
                    if (over_thr)
                    begin
                        new_state.phase = PHASE_HELD;
                        new_kind        = EV_HELD;
                    end
                end
                default:
                begin
                    new_state.phase = PHASE_HELD;
                    new_kind        = EV_HELD;
                end
            endcase
        end
    end

    // The table is written as the item moves into the result register.
    assign wr.en   = v2_reg && en3 && key2_ok;
    assign wr.addr = ADDR_W'(key2_reg);
    assign wr.data = new_state;

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            byp1_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg   <= accept;
                byp1_reg <= wr.en && (wr.addr == in_addr);
            end
            else if (wr.en && (wr.addr == addr1))
            begin
                byp1_reg <= 1'b1;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            key1_reg      <= in_key;
            down1_reg     <= in_down;
            byp1_data_reg <= wr.data;
        end
        else if (wr.en && (wr.addr == addr1))
        begin
            byp1_data_reg <= wr.data;
        end
        if (en2)
        begin
            key2_reg  <= key1_reg;
            down2_reg <= down1_reg;
            st2_reg   <= st2_next;
        end
        if (en3)
        begin
            key3_reg <= key2_reg;
            if (key2_ok)
            begin
                kind3_reg <= new_kind;
                cnt3_reg  <= new_state.count;
            end
            else
            begin
                kind3_reg <= EV_NONE;
                cnt3_reg  <= '0;
            end
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tuser  = kind3_reg;
    assign m_axis_tdata  = {7'd0, cnt3_reg, key3_reg};

    // Once the clearing sweep has finished it never starts again.
    assert property (@(posedge clk) disable iff (!rst_n) !clr_busy |=> !clr_busy)
        else $error("table clearing restarted");

    // No item may enter while the table is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n) clr_busy |-> !accept)
        else $error("item accepted during table clearing");

    // A released key always reports a zero count, a pressed key a count of one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && (kind3_reg == EV_RELEASED)) |-> (cnt3_reg == '0))
        else $error("release with non-zero count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && (kind3_reg == EV_PRESSED)) |-> (cnt3_reg == CNT_W'(1)))
        else $error("press with count other than one");

    // Held can only follow a press and at least one blocked frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && (kind3_reg == EV_HELD)) |-> (cnt3_reg >= CNT_W'(3)))
        else $error("held reported too early");

endmodule

// ===== design/khd_key_table.sv =====
`timescale 1ns / 1ps

module khd_key_table (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [khd_pkg::ADDR_W-1:0] rd_addr,
    output khd_pkg::key_state_t       rd_data,
    input  khd_pkg::table_wr_t        wr,
    output logic                      clr_busy
);
    import khd_pkg::*;

    key_state_t        mem [KEY_COUNT];
    key_state_t        rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    key_state_t        mem_wdata;

    // After reset every entry is swept back to released with a zero count.
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(KEY_COUNT - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '{phase: PHASE_RELEASED, count: '0};
        end
        else
        begin
            mem_we    = wr.en;
            mem_waddr = wr.addr;
            mem_wdata = wr.data;
        end
    end

    // Read returns the contents from before a write at the same edge.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for key_hold_detector. Key samples are streamed into the
// block while a behavioural copy of the key table predicts the event of every
// accepted item. Each result item is checked field by field against the oldest
// prediction still outstanding. Both stream sides idle at random, with bursts
// that have no idling at all. The hold threshold is only rewritten once the
// block has drained.
module tb;
    import khd_pkg::*;

    // Generous ceiling on the run length.
    localparam int CYCLE_LIMIT    = 200_000;
    // Down frames on one key while the threshold is at its maximum.
    localparam int BLOCKED_FRAMES = 40;
    // Number of random items in each threshold phase.
    localparam int PHASE_ITEMS    = 90;

    // One predicted result item.
    typedef struct packed {
        kind_t             kind;
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  frames;
    } key_event_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // [8:0] key_index, [9] key_down, rest zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [8:0] event_key, [24:9] held_frames, rest zero
    logic [1:0]  m_axis_tuser;          // [1:0] event_kind

    // Behavioural copy of the key table and of the threshold register.
    phase_t           phase_copy [KEY_COUNT];
    logic [CNT_W-1:0] count_copy [KEY_COUNT];
    logic [CNT_W-1:0] threshold_copy = THRESHOLD_RESET;

    // Events predicted for accepted items whose results have not come back yet.
    key_event_t expected_events[$];

    int  failures    = 0;
    int  cycle_count = 0;
    // When set, neither side idles, so items flow at the full rate.
    bit  no_gaps     = 1'b0;

    key_hold_detector u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    // Watchdog: a hung handshake must not leave the run going forever.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** key_hold_detector: FAILED **");
            $finish;
        end
    end

    // Idle cycles before the next item on either side. Roughly a third of the
    // draws are zero, so short back-to-back runs turn up even between bursts.
    function automatic int draw_gap();
        if (no_gaps)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(1, 17);
    endfunction

    // Advances the copy of the key table by one sample and returns the event
    // that the block should report for it. The count is taken before the
    // increment when deciding whether a blocked key becomes held.
    function automatic key_event_t next_key_event(logic [KEY_W-1:0] key, logic down);
        key_event_t       ev;
        phase_t           ph;
        logic [CNT_W-1:0] cnt;
        ev.kind   = EV_NONE;
        ev.key    = key;
        ev.frames = '0;
        // A key beyond the table is ignored; it cannot occur with a full table.
        if (int'(key) >= KEY_COUNT)
            return ev;
        ph  = phase_copy[key];
        cnt = count_copy[key];
        if (!down)
        begin
            ph      = PHASE_RELEASED;
            cnt     = '0;
            ev.kind = EV_RELEASED;
        end
        else
        begin
            case (ph)
                PHASE_RELEASED:
                begin
                    ph      = PHASE_PRESSED;
                    ev.kind = EV_PRESSED;
                end
                // A pressed key always moves on, even with a threshold of zero.
                PHASE_PRESSED:
                    ph = PHASE_BLOCKED;
                PHASE_BLOCKED:
                    if (cnt > threshold_copy)
                    begin
                        ph      = PHASE_HELD;
                        ev.kind = EV_HELD;
                    end
                default:
                    ev.kind = EV_HELD;
            endcase
            if (cnt != COUNT_MAX)
                cnt = cnt + 1'b1;
        end
        phase_copy[key] = ph;
        count_copy[key] = cnt;
        ev.frames       = cnt;
        return ev;
    endfunction

    // Monitor on all three channels, sampled at the rising edge. The register
    // write and the prediction are taken before the result check so that the
    // order of events within the edge never matters.
    always @(posedge clk)
    begin
        key_event_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                threshold_copy = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                expected_events.push_back(next_key_event(s_axis_tdata[8:0], s_axis_tdata[9]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("result item with nothing expected: key %0d kind %0d frames %0d",
                           m_axis_tdata[8:0], m_axis_tuser, m_axis_tdata[24:9]);
                    failures++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (m_axis_tuser !== want.kind)
                    begin
                        $error("event_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                        failures++;
                    end
                    if (m_axis_tdata[8:0] !== want.key)
                    begin
                        $error("event_key: expected %0d, got %0d", want.key, m_axis_tdata[8:0]);
                        failures++;
                    end
                    if (m_axis_tdata[24:9] !== want.frames)
                    begin
                        $error("held_frames: expected %0d, got %0d",
                               want.frames, m_axis_tdata[24:9]);
                        failures++;
                    end
                end
            end
        end
    end

    // Result side: waits a random number of cycles before each item, then holds
    // tready high until an item has been taken.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            @(negedge clk);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // Presents one key sample after a random pause and returns at the edge at
    // which it is accepted. tvalid is left high, so that the next call can keep
    // it up without a glitch; whatever follows the last call lowers it.
    task automatic send_sample(input logic [KEY_W-1:0] key, input logic down);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, down, key};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Stops the item stream and waits until every predicted result has been
    // seen, then waits further so that the pipeline is empty.
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Writes hold_threshold; only called while the block is idle.
    task automatic write_threshold(input logic [CNT_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random key activity. Most items come from a small pool of keys that stay
    // down for long runs, so that keys get through blocked into held; the rest
    // are samples of any key with any level. up_odds sets the chance of an up
    // sample on a pooled key to one in up_odds + 1. Gaps are switched off for
    // every so often a whole block of 25 items.
    task automatic send_random_samples(input int count, input int pool_size, input int up_odds);
        logic [KEY_W-1:0] pool [6];
        for (int i = 0; i < 6; i++)
            pool[i] = KEY_W'($urandom_range(0, KEY_COUNT - 1));
        // Now and then the pool takes the first and the last key of the table.
        if ($urandom_range(0, 2) == 0)
            pool[0] = '0;
        if ($urandom_range(0, 2) == 0)
            pool[pool_size - 1] = KEY_W'(KEY_COUNT - 1);
        for (int i = 0; i < count; i++)
        begin
            if (i % 25 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                send_sample(KEY_W'($urandom_range(0, KEY_COUNT - 1)),
                            1'($urandom_range(0, 1)));
            else
                send_sample(pool[$urandom_range(0, pool_size - 1)],
                            $urandom_range(0, up_odds) != 0);
        end
        no_gaps = 1'b0;
    endtask

    // Runs at the threshold left by reset, with long down runs on two keys so
    // that held events appear after the default 22 frames.
    task automatic test_reset_threshold();
        send_random_samples(PHASE_ITEMS, 2, 40);
        drain_results();
    endtask

    // Short hand-written sequences: a threshold of one, a threshold of zero,
    // the first and last keys, repeated releases and back-to-back samples.
    task automatic test_directed_edges();
        write_threshold(16'd1);
        // Press, blocked, then held on the third down frame.
        repeat (4) send_sample(9'd0, 1'b1);
        // Release twice: an up key reports on every frame.
        repeat (2) send_sample(9'd0, 1'b0);
        send_sample(9'd511, 1'b1);
        send_sample(9'd511, 1'b0);
        send_sample(9'd511, 1'b1);
        drain_results();

        // With a threshold of zero the key still passes through blocked once.
        write_threshold(16'd0);
        send_sample(9'd300, 1'b1);
        send_sample(9'd301, 1'b1);
        send_sample(9'd300, 1'b1);
        send_sample(9'd300, 1'b1);
        send_sample(9'd301, 1'b1);
        send_sample(9'd300, 1'b0);
        send_sample(9'd301, 1'b1);
        drain_results();
    endtask

    // Holds one key down with the threshold at its maximum, where the count can
    // never pass it and the key stays blocked; a lower threshold then lets the
    // key become held on its next down frame.
    task automatic test_max_threshold();
        no_gaps = 1'b1;
        write_threshold(16'hFFFF);
        send_sample(9'd77, 1'b0);
        repeat (BLOCKED_FRAMES) send_sample(9'd77, 1'b1);
        drain_results();
        write_threshold(CNT_W'(BLOCKED_FRAMES - 10));
        repeat (3) send_sample(9'd77, 1'b1);
        send_sample(9'd77, 1'b0);
        drain_results();
        no_gaps = 1'b0;
    endtask

    // Random phases across a range of thresholds, extremes included. Small
    // thresholds get one to six keys with shorter runs; large ones get two keys
    // that stay down for long.
    task automatic test_random_thresholds();
        logic [CNT_W-1:0] threshold;
        for (int phase_no = 0; phase_no < 6; phase_no++)
        begin
            case (phase_no)
                0:       threshold = 16'd1;
                1:       threshold = 16'hFFFE;
                2:       threshold = 16'd0;
                3:       threshold = CNT_W'($urandom_range(2, 8));
                4:       threshold = CNT_W'($urandom_range(9, 40));
                default: threshold = CNT_W'($urandom_range(0, 16'hFFFF));
            endcase
            write_threshold(threshold);
            if (threshold <= 8)
                send_random_samples(PHASE_ITEMS, $urandom_range(1, 6), 12);
            else
                send_random_samples(PHASE_ITEMS, 2, 60);
            drain_results();
        end
    endtask

    initial
    begin
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            phase_copy[i] = PHASE_RELEASED;
            count_copy[i] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The block clears its table after reset; the first send simply waits
        // for tready.
        test_reset_threshold();
        test_directed_edges();
        test_max_threshold();
        test_random_thresholds();

        if (failures == 0)
            $display("** key_hold_detector: PASSED **");
        else
            $display("** key_hold_detector: FAILED **");
        $finish;
    end

endmodule
